### sv/pirf_pkg.sv
// ----------------------------------------------------------------------------
// pirf_pkg
// Shared widths, vector types and the rotation helper for the polyphase
// input rotate/format block.
// ----------------------------------------------------------------------------
package pirf_pkg;

  localparam int SAMPLE_W         = 32;
  localparam int VECTOR_LEN       = 16;
  localparam int IN_LANES         = 7;
  localparam int OUT_LANES        = 8;
  localparam int DELAY_FRAMES_DEF = 3;
  localparam int LANE_W           = 3;
  localparam int WORD_W           = 2 * SAMPLE_W;
  localparam int ROW_W            = 2 * VECTOR_LEN * SAMPLE_W;

  // lane codes on the input channel
  localparam logic [LANE_W-1:0] LAST_LANE = LANE_W'(IN_LANES - 1);
  localparam logic [LANE_W-1:0] NULL_LANE = LANE_W'(IN_LANES);

  // output slot code of the final word of a frame
  localparam logic [LANE_W-1:0] LAST_SLOT = LANE_W'(OUT_LANES - 1);

  typedef logic [SAMPLE_W-1:0] sample_t;
  typedef logic [WORD_W-1:0]   word_t;
  typedef sample_t [VECTOR_LEN-1:0] vec_t;

  // control handed from the top level to every slot formatter
  typedef struct packed {
    logic load;   // delayed vectors advance into the slots this cycle
    logic odd;    // frame parity of the frame being loaded
  } slot_ctl_t;

  // out[(m + 2*ph) mod 16] = v[m]
  function automatic vec_t rotate_vec(input vec_t v, input logic [2:0] ph);
    vec_t r;
    for (int k = 0; k < VECTOR_LEN; k++) begin
      r[k] = v[4'(k) - {ph, 1'b0}];
    end
    return r;
  endfunction

endpackage

### sv/pirf_ifc.sv
// ----------------------------------------------------------------------------
// pirf_ifc
// Valid/ready channel interfaces for lane words in and formatted words out.
// ----------------------------------------------------------------------------
interface pirf_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  lane;
  logic [63:0] word_low;
  logic [63:0] word_high;

  modport source (output valid, lane, word_low, word_high, input ready);
  modport sink   (input valid, lane, word_low, word_high, output ready);
endinterface

interface pirf_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  out_lane;
  logic [63:0] out_low;
  logic [63:0] out_high;
  logic        frame_end;

  modport source (output valid, out_lane, out_low, out_high, frame_end, input ready);
  modport sink   (input valid, out_lane, out_low, out_high, frame_end, output ready);
endinterface

### sv/pirf_gather.sv
// ----------------------------------------------------------------------------
// pirf_gather
// Collects lane words 0..5, completes A with the lane 6 word and history,
// B with lane 6 and A's first samples; rotates them by the running phase.
// ----------------------------------------------------------------------------
module pirf_gather (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       wr_en,
  input  logic [pirf_pkg::LANE_W-1:0] lane,
  input  logic [63:0]                word_low,
  input  logic [63:0]                word_high,
  output pirf_pkg::vec_t             rot_a,
  output pirf_pkg::vec_t             rot_b
);
  import pirf_pkg::*;

  // lanes 0..5 kept as {word_high, word_low}; no reset, written before use
  logic [2*WORD_W-1:0] lane_store [IN_LANES-1];
  sample_t             hist [2];
  logic [2:0]          phase;
  vec_t                vec_a;
  vec_t                vec_b;
  logic                fire;

  assign fire = wr_en && (lane == LAST_LANE);

  // lane store write
  always_ff @(posedge clk) begin
    if (wr_en && (lane < LAST_LANE)) begin
      lane_store[lane] <= {word_high, word_low};
    end
  end

  // vector assembly: the lane 6 word comes straight from the input
  always_comb begin
    for (int l = 0; l < IN_LANES - 1; l++) begin
      vec_a[l]            = lane_store[l][SAMPLE_W-1:0];
      vec_a[l + IN_LANES] = lane_store[l][WORD_W-1:SAMPLE_W];
      vec_b[l]            = lane_store[l][WORD_W+SAMPLE_W-1:WORD_W];
      vec_b[l + IN_LANES] = lane_store[l][2*WORD_W-1:WORD_W+SAMPLE_W];
    end
    vec_a[IN_LANES-1]   = word_low[SAMPLE_W-1:0];
    vec_a[2*IN_LANES-1] = word_low[WORD_W-1:SAMPLE_W];
    vec_b[IN_LANES-1]   = word_high[SAMPLE_W-1:0];
    vec_b[2*IN_LANES-1] = word_high[WORD_W-1:SAMPLE_W];
    vec_a[VECTOR_LEN-2] = hist[0];
    vec_a[VECTOR_LEN-1] = hist[1];
    vec_b[VECTOR_LEN-2] = vec_a[0];
    vec_b[VECTOR_LEN-1] = vec_a[1];
  end

  assign rot_a = rotate_vec(vec_a, phase);
  assign rot_b = rotate_vec(vec_b, phase + 3'd1);

  // history and phase advance once per completed frame
  always_ff @(posedge clk) begin
    if (rst) begin
      hist[0] <= '0;
      hist[1] <= '0;
      phase   <= '0;
    end else if (fire) begin
      hist[0] <= vec_b[0];
      hist[1] <= vec_b[1];
      phase   <= phase + 3'd2;
    end
  end

endmodule

### sv/pirf_delay.sv
// ----------------------------------------------------------------------------
// pirf_delay
// Frame delay line: one row of both rotated vectors per frame, read before
// write at a circular pointer. Rows never written read back as zero.
// ----------------------------------------------------------------------------
module pirf_delay #(
  parameter int DELAY_FRAMES = pirf_pkg::DELAY_FRAMES_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  pirf_pkg::vec_t wr_a,
  input  pirf_pkg::vec_t wr_b,
  output pirf_pkg::vec_t rd_a,
  output pirf_pkg::vec_t rd_b
);
  import pirf_pkg::*;

  localparam int PTR_W = (DELAY_FRAMES > 1) ? $clog2(DELAY_FRAMES) : 1;

  logic [ROW_W-1:0]        mem [DELAY_FRAMES];
  logic [DELAY_FRAMES-1:0] row_valid;
  logic [PTR_W-1:0]        ptr;
  logic [ROW_W-1:0]        rd_row;
  logic                    rd_valid;

  // memory port: old row out, new row in
  always_ff @(posedge clk) begin
    if (en) begin
      rd_row   <= mem[ptr];
      mem[ptr] <= {wr_b, wr_a};
    end
  end

  // pointer, row valid bits and read-valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      ptr       <= '0;
      row_valid <= '0;
      rd_valid  <= 1'b0;
    end else if (en) begin
      rd_valid       <= row_valid[ptr];
      row_valid[ptr] <= 1'b1;
      ptr            <= (ptr == PTR_W'(DELAY_FRAMES - 1)) ? '0 : ptr + 1'b1;
    end
  end

  assign rd_a = rd_valid ? rd_row[ROW_W/2-1:0]     : '0;
  assign rd_b = rd_valid ? rd_row[ROW_W-1:ROW_W/2] : '0;

endmodule

### sv/pirf_slot.sv
// ----------------------------------------------------------------------------
// pirf_slot
// Formatter for one output slot: pairs the even samples with the previous
// vectors on even frames, sends the saved odd-sample words on odd frames.
// ----------------------------------------------------------------------------
module pirf_slot (
  input  logic                clk,
  input  logic                rst,
  input  pirf_pkg::slot_ctl_t ctl,
  input  pirf_pkg::sample_t   da_even,
  input  pirf_pkg::sample_t   da_odd,
  input  pirf_pkg::sample_t   db_even,
  input  pirf_pkg::sample_t   db_odd,
  output pirf_pkg::word_t     word_lo,
  output pirf_pkg::word_t     word_hi
);
  import pirf_pkg::*;

  sample_t prev_a_even, prev_a_odd, prev_b_even, prev_b_odd;
  word_t   saved_lo, saved_hi;

  // previous vectors: updated on odd frames
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_a_even <= '0;
      prev_a_odd  <= '0;
      prev_b_even <= '0;
      prev_b_odd  <= '0;
    end else if (ctl.load && ctl.odd) begin
      prev_a_even <= da_even;
      prev_a_odd  <= da_odd;
      prev_b_even <= db_even;
      prev_b_odd  <= db_odd;
    end
  end

  // saved words and the outgoing word pair
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      if (ctl.odd) begin
        word_lo <= saved_lo;
        word_hi <= saved_hi;
      end else begin
        word_lo  <= {prev_b_even, prev_a_even};
        word_hi  <= {db_even, da_even};
        saved_lo <= {prev_b_odd, prev_a_odd};
        saved_hi <= {db_odd, da_odd};
      end
    end
  end

endmodule

### sv/polyphase_input_rotate_format_top.sv
// ----------------------------------------------------------------------------
// polyphase_input_rotate_format_top
// Input permutation for a 16-channel polyphase channelizer.
// ----------------------------------------------------------------------------
// Channels: din takes lane words 0..6 of a frame in order (lane 7 is taken
// and dropped); dout sends 8 formatted words per frame, out_lane 0..7, with
// frame_end on the eighth. Transfers happen when valid and ready are high.
// Flow: a frame goes from the lane 6 transfer through the delay-line read
// into the 8 slot formatters and is then sent as one word per cycle while
// dout is ready.
// Throughput: one lane word per cycle on din while din.ready is high; a
// frame occupies dout for 8 words, so the serializer sets the sustained rate.
// din.ready drops only while a completed frame waits for the slot registers,
// which free up as the last word of the previous frame transfers.
// Reset: clears history, phase, delay pointer (unwritten delay rows read as
// zero), frame parity, previous vectors and the output buffer. Lane words
// 0..5 must be sent again after reset before a lane 6 word.
// Stall: dout holds its word while ready is low; a further completed frame
// parks in the delay-read stage and din stalls behind it.
// ----------------------------------------------------------------------------
module polyphase_input_rotate_format_top #(
  parameter int DELAY_FRAMES = pirf_pkg::DELAY_FRAMES_DEF
) (
  input  logic       clk,
  input  logic       rst,
  pirf_in_if.sink    din,
  pirf_out_if.source dout
);
  import pirf_pkg::*;

  logic              in_xfer, fire, out_xfer;
  logic              s1_v, s1_adv;
  logic              buf_v;
  logic [LANE_W-1:0] cnt;
  logic              odd_frame;
  slot_ctl_t         ctl;
  vec_t              rot_a, rot_b, dly_a, dly_b;
  word_t             slot_lo [OUT_LANES];
  word_t             slot_hi [OUT_LANES];

  // handshake
  assign s1_adv    = s1_v && (!buf_v || (out_xfer && (cnt == LAST_SLOT)));
  assign din.ready = !s1_v || s1_adv;
  assign in_xfer   = din.valid && din.ready;
  assign fire      = in_xfer && (din.lane == LAST_LANE);
  assign out_xfer  = dout.valid && dout.ready;

  pirf_gather u_gather (
    .clk       (clk),
    .rst       (rst),
    .wr_en     (in_xfer && (din.lane != NULL_LANE)),
    .lane      (din.lane),
    .word_low  (din.word_low),
    .word_high (din.word_high),
    .rot_a     (rot_a),
    .rot_b     (rot_b)
  );

  pirf_delay #(.DELAY_FRAMES(DELAY_FRAMES)) u_delay (
    .clk  (clk),
    .rst  (rst),
    .en   (fire),
    .wr_a (rot_a),
    .wr_b (rot_b),
    .rd_a (dly_a),
    .rd_b (dly_b)
  );

  // delay-read stage valid and frame parity
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v      <= 1'b0;
      odd_frame <= 1'b0;
    end else begin
      if (fire) begin
        s1_v <= 1'b1;
      end else if (s1_adv) begin
        s1_v <= 1'b0;
      end
      if (s1_adv) begin
        odd_frame <= !odd_frame;
      end
    end
  end

  assign ctl.load = s1_adv;
  assign ctl.odd  = odd_frame;

  // one formatter per output slot
  for (genvar s = 0; s < OUT_LANES; s++) begin : g_slot
    pirf_slot u_slot (
      .clk     (clk),
      .rst     (rst),
      .ctl     (ctl),
      .da_even (dly_a[2*s]),
      .da_odd  (dly_a[2*s+1]),
      .db_even (dly_b[2*s]),
      .db_odd  (dly_b[2*s+1]),
      .word_lo (slot_lo[s]),
      .word_hi (slot_hi[s])
    );
  end

  // serializer over the slot registers
  always_ff @(posedge clk) begin
    if (rst) begin
      buf_v <= 1'b0;
      cnt   <= '0;
    end else if (s1_adv) begin
      buf_v <= 1'b1;
      cnt   <= '0;
    end else if (out_xfer) begin
      if (cnt == LAST_SLOT) begin
        buf_v <= 1'b0;
      end
      cnt <= cnt + 1'b1;
    end
  end

  assign dout.valid     = buf_v;
  assign dout.out_lane  = cnt;
  assign dout.out_low   = slot_lo[cnt];
  assign dout.out_high  = slot_hi[cnt];
  assign dout.frame_end = (cnt == LAST_SLOT);

  // first word of a loaded frame is slot 0
  a_load_starts_frame: assert property (@(posedge clk) disable iff (rst)
    s1_adv |=> (dout.valid && (dout.out_lane == '0)))
    else $error("frame load did not restart at slot 0");

  // a parked frame must block the input
  a_park_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (s1_v && !s1_adv) |-> !din.ready)
    else $error("input ready while delay stage is parked");

  // parity flips exactly with each frame load
  a_parity_flip: assert property (@(posedge clk) disable iff (rst)
    s1_adv |=> (odd_frame != $past(odd_frame)))
    else $error("frame parity did not toggle on load");

  // last word out with nothing pending empties the buffer
  a_buffer_drains: assert property (@(posedge clk) disable iff (rst)
    (out_xfer && dout.frame_end && !s1_adv) |=> !dout.valid)
    else $error("output buffer still valid after frame end");

endmodule
